/* sv/char_lcd_4bit_write_sequencer_core_macros.svh */
// Assertion macros shared by the sequencer modules.
`ifndef CHAR_LCD_4BIT_WRITE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LCD4W_ASSERT(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
        else $error("lcd4w assertion failed");
`define LCD4W_ASSERT_IMP(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("lcd4w implication failed");
`else
`define LCD4W_ASSERT(lbl, clk, rst, prop)
`define LCD4W_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/lcd4w_pkg.sv */
package lcd4w_pkg;

    localparam int OPCODE_W    = 3;
    localparam int BYTE_W      = 8;
    localparam int LINE_SEL_W  = 2;
    localparam int NIBBLE_W    = 4;
    localparam int HOLD_W      = 18;
    localparam int WAIT_W      = 16;
    localparam int PULSE_W     = 8;
    localparam int COL_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int INIT_IDX_W  = 3;

    localparam int LINE_CHARS_DEFAULT = 16;

    localparam logic [PULSE_W-1:0] PULSE_RESET   = 8'd40;
    localparam logic [WAIT_W-1:0]  DATA_RESET    = 16'd2000;
    localparam logic [WAIT_W-1:0]  COMMAND_RESET = 16'd5000;
    localparam logic [WAIT_W-1:0]  STARTUP_RESET = 16'd20000;

    localparam logic [INIT_IDX_W-1:0] INIT_LAST_IDX = 3'd5;
    localparam logic [LINE_SEL_W-1:0] LINE_TWO_SEL  = 2'd2;

    localparam logic [BYTE_W-1:0] LINE_ONE_ADDR = 8'h80;
    localparam logic [BYTE_W-1:0] LINE_TWO_ADDR = 8'hC0;
    localparam logic [BYTE_W-1:0] SPACE_CHAR    = 8'h20;

    typedef enum logic [OPCODE_W-1:0] {
        OP_COMMAND = 3'd0,
        OP_DATA    = 3'd1,
        OP_INIT    = 3'd2,
        OP_LINE    = 3'd3,
        OP_PAD     = 3'd4
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE   = 2'd0,
        CFG_DATA    = 2'd1,
        CFG_COMMAND = 2'd2,
        CFG_STARTUP = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SRC_REQ,
        SRC_INIT,
        SRC_LINE,
        SRC_SPACE
    } byte_src_t;

    typedef enum logic [2:0] {
        HOLD_PULSE,
        HOLD_DATA,
        HOLD_CMD,
        HOLD_START,
        HOLD_CMD_START,
        HOLD_CMD_TWICE
    } hold_sel_t;

    typedef enum logic [1:0] {
        COL_KEEP,
        COL_INC,
        COL_CLEAR
    } col_op_t;

    typedef struct packed {
        logic                  load;
        logic                  emit;
        logic                  rs;
        logic                  enable;
        logic                  low_half;
        logic                  zero_nibble;
        byte_src_t             src;
        logic [INIT_IDX_W-1:0] init_idx;
        hold_sel_t             hold;
        logic                  last;
        col_op_t               col_op;
    } lcd4w_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic col_full;
        logic col_last;
    } lcd4w_stat_t;

    function automatic logic [BYTE_W-1:0] init_cmd(input logic [INIT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h33;
            3'd2:    b = 8'h32;
            3'd3:    b = 8'h28;
            3'd4:    b = 8'h0C;
            3'd5:    b = 8'h01;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

/* sv/lcd4w_if.sv */
interface lcd4w_req_if import lcd4w_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [BYTE_W-1:0]     byte_value;
    logic [LINE_SEL_W-1:0] line_select;

    modport source (output valid, opcode, byte_value, line_select, input ready);
    modport sink   (input valid, opcode, byte_value, line_select, output ready);
endinterface

interface lcd4w_res_if import lcd4w_pkg::*;;
    logic                valid;
    logic                ready;
    logic                reg_select;
    logic                enable;
    logic [NIBBLE_W-1:0] nibble;
    logic [HOLD_W-1:0]   hold_us;
    logic                last;

    modport source (output valid, reg_select, enable, nibble, hold_us, last, input ready);
    modport sink   (input valid, reg_select, enable, nibble, hold_us, last, output ready);
endinterface

/* sv/char_lcd_4bit_write_sequencer_core.sv */
// Channel   Dir   Payload                                         Word
// request   in    opcode[2:0] byte_value[7:0] line_select[1:0]    one LCD operation
// result    out   reg_select enable nibble[3:0] hold_us[17:0] last one pin state
// cfg       in    cfg_we cfg_index[1:0] cfg_data[15:0]            register write
//
// A request is accepted whenever the controller is idle; it goes idle as
// the last word of a request loads into the output register, before that word is taken.
// Words then follow one per cycle while result.ready holds high: command, data and line
// give four words each, init twenty-five, pad four per space, unknown opcodes none.
// A stalled word holds the output register and the controller until it is taken.
// Reset loads the register defaults and clears the column count.
module char_lcd_4bit_write_sequencer_core
    import lcd4w_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lcd4w_req_if.sink             request,
    lcd4w_res_if.source           result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lcd4w_cmd_t  cmd;
    lcd4w_stat_t status;

    lcd4w_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_opcode (request.opcode),
        .status     (status),
        .req_ready  (request.ready),
        .cmd        (cmd)
    );

    lcd4w_dpath #(
        .LINE_CHARS (LINE_CHARS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .byte_value   (request.byte_value),
        .line_select  (request.line_select),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .reg_select   (result.reg_select),
        .enable       (result.enable),
        .nibble       (result.nibble),
        .hold_us      (result.hold_us),
        .last         (result.last)
    );

endmodule

/* sv/lcd4w_ctrl.sv */
`include "char_lcd_4bit_write_sequencer_core_macros.svh"

module lcd4w_ctrl
    import lcd4w_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [OPCODE_W-1:0] req_opcode,
    input  lcd4w_stat_t         status,
    output logic                req_ready,
    output lcd4w_cmd_t          cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STARTUP,
        S_BYTE
    } state_t;

    state_t                state_reg, state_next;
    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic [1:0]            phase_reg, phase_next;
    logic [INIT_IDX_W-1:0] idx_reg, idx_next;
    logic                  accept;
    logic                  final_phase;

    assign req_ready   = (state_reg == S_IDLE);
    assign accept      = req_valid && req_ready;
    assign final_phase = (phase_reg == 2'd3);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        cmd              = '0;
        cmd.src          = SRC_REQ;
        cmd.hold         = HOLD_PULSE;
        cmd.col_op       = COL_KEEP;
        cmd.init_idx     = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    op_next    = req_opcode;
                    phase_next = 2'd0;
                    idx_next   = '0;
                    case (req_opcode)
                        OP_COMMAND, OP_DATA:
                        begin
                            state_next = S_BYTE;
                        end
                        OP_LINE:
                        begin
                            cmd.col_op = COL_CLEAR;
                            state_next = S_BYTE;
                        end
                        OP_INIT:
                        begin
                            cmd.col_op = COL_CLEAR;
                            state_next = S_STARTUP;
                        end
                        OP_PAD:
                        begin
                            if (!status.col_full)
                            begin
                                state_next = S_BYTE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_STARTUP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.zero_nibble = 1'b1;
                    cmd.hold        = HOLD_START;
                    state_next      = S_BYTE;
                end
            end

            S_BYTE:
            begin
                cmd.enable   = ~phase_reg[0];
                cmd.low_half = phase_reg[1];
                cmd.rs       = (op_reg == OP_DATA) || (op_reg == OP_PAD);
                case (op_reg)
                    OP_INIT:  cmd.src = SRC_INIT;
                    OP_LINE:  cmd.src = SRC_LINE;
                    OP_PAD:   cmd.src = SRC_SPACE;
                    default:  cmd.src = SRC_REQ;
                endcase
                if (final_phase)
                begin
                    case (op_reg)
                        OP_COMMAND:
                        begin
                            cmd.hold = HOLD_CMD;
                            cmd.last = 1'b1;
                        end
                        OP_DATA:
                        begin
                            cmd.hold   = HOLD_DATA;
                            cmd.col_op = COL_INC;
                            cmd.last   = 1'b1;
                        end
                        OP_LINE:
                        begin
                            cmd.hold = HOLD_CMD_TWICE;
                            cmd.last = 1'b1;
                        end
                        OP_INIT:
                        begin
                            cmd.last = (idx_reg == INIT_LAST_IDX);
                            cmd.hold = cmd.last ? HOLD_CMD_START : HOLD_CMD;
                        end
                        default:
                        begin
                            cmd.hold   = HOLD_DATA;
                            cmd.col_op = COL_INC;
                            cmd.last   = status.col_last;
                        end
                    endcase
                end
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    phase_next = phase_reg + 2'd1;
                    if (final_phase)
                    begin
                        idx_next = idx_reg + 3'd1;
                        if (cmd.last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.col_op = COL_KEEP;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            phase_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    `LCD4W_ASSERT_IMP(a_emit_busy, clk, rst_n, cmd.emit, state_reg != S_IDLE)
    `LCD4W_ASSERT(a_last_to_idle, clk, rst_n, (cmd.emit && cmd.last) |=> state_reg == S_IDLE)
    `LCD4W_ASSERT_IMP(a_phase_in_byte, clk, rst_n, phase_reg != 2'd0, state_reg == S_BYTE)
    `LCD4W_ASSERT_IMP(a_init_idx, clk, rst_n, state_reg == S_BYTE && op_reg == OP_INIT,
                      idx_reg <= INIT_LAST_IDX)

endmodule

/* sv/lcd4w_dpath.sv */
`include "char_lcd_4bit_write_sequencer_core_macros.svh"

module lcd4w_dpath
    import lcd4w_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcd4w_cmd_t            cmd,
    output lcd4w_stat_t           status,
    input  logic [BYTE_W-1:0]     byte_value,
    input  logic [LINE_SEL_W-1:0] line_select,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  result_ready,
    output logic                  result_valid,
    output logic                  reg_select,
    output logic                  enable,
    output logic [NIBBLE_W-1:0]   nibble,
    output logic [HOLD_W-1:0]     hold_us,
    output logic                  last
);

    localparam logic [COL_W-1:0] LINE_LIM = COL_W'(LINE_CHARS);

    logic [PULSE_W-1:0]  pulse_reg;
    logic [WAIT_W-1:0]   data_wait_reg;
    logic [WAIT_W-1:0]   cmd_wait_reg;
    logic [WAIT_W-1:0]   start_wait_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [BYTE_W-1:0]   byte_reg;
    logic                line_two_reg;
    logic                valid_reg, valid_next;
    logic                rs_reg;
    logic                en_reg;
    logic [NIBBLE_W-1:0] nib_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic                last_reg;

    logic [BYTE_W-1:0]   cur_byte;
    logic [NIBBLE_W-1:0] cur_nib;
    logic [HOLD_W-1:0]   cur_hold;

    assign status.slot_free = !valid_reg || result_ready;
    assign status.col_full  = (col_reg >= LINE_LIM);
    assign status.col_last  = (col_reg == LINE_LIM - COL_W'(1));

    always_comb
    begin
        case (cmd.src)
            SRC_INIT:  cur_byte = init_cmd(cmd.init_idx);
            SRC_LINE:  cur_byte = line_two_reg ? LINE_TWO_ADDR : LINE_ONE_ADDR;
            SRC_SPACE: cur_byte = SPACE_CHAR;
            default:   cur_byte = byte_reg;
        endcase

        if (cmd.zero_nibble)
            cur_nib = '0;
        else if (cmd.low_half)
            cur_nib = cur_byte[3:0];
        else
            cur_nib = cur_byte[7:4];

        case (cmd.hold)
            HOLD_DATA:      cur_hold = HOLD_W'(data_wait_reg);
            HOLD_CMD:       cur_hold = HOLD_W'(cmd_wait_reg);
            HOLD_START:     cur_hold = HOLD_W'(start_wait_reg);
            HOLD_CMD_START: cur_hold = HOLD_W'(cmd_wait_reg) + HOLD_W'(start_wait_reg);
            HOLD_CMD_TWICE: cur_hold = HOLD_W'({cmd_wait_reg, 1'b0});
            default:        cur_hold = HOLD_W'(pulse_reg);
        endcase

        case (cmd.col_op)
            COL_CLEAR: col_next = '0;
            COL_INC:   col_next = status.col_full ? col_reg : col_reg + COL_W'(1);
            default:   col_next = col_reg;
        endcase

        if (cmd.emit)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg      <= PULSE_RESET;
            data_wait_reg  <= DATA_RESET;
            cmd_wait_reg   <= COMMAND_RESET;
            start_wait_reg <= STARTUP_RESET;
            col_reg        <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PULSE:   pulse_reg      <= cfg_data[PULSE_W-1:0];
                    CFG_DATA:    data_wait_reg  <= cfg_data[WAIT_W-1:0];
                    CFG_COMMAND: cmd_wait_reg   <= cfg_data[WAIT_W-1:0];
                    default:     start_wait_reg <= cfg_data[WAIT_W-1:0];
                endcase
            end
            col_reg   <= col_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg     <= byte_value;
            line_two_reg <= (line_select == LINE_TWO_SEL);
        end
        if (cmd.emit)
        begin
            rs_reg   <= cmd.rs;
            en_reg   <= cmd.enable;
            nib_reg  <= cur_nib;
            hold_reg <= cur_hold;
            last_reg <= cmd.last;
        end
    end

    assign result_valid = valid_reg;
    assign reg_select   = rs_reg;
    assign enable       = en_reg;
    assign nibble       = nib_reg;
    assign hold_us      = hold_reg;
    assign last         = last_reg;

    `LCD4W_ASSERT_IMP(a_col_bound, clk, rst_n, 1'b1, col_reg <= LINE_LIM)
    `LCD4W_ASSERT_IMP(a_emit_slot, clk, rst_n, cmd.emit, !valid_reg || result_ready)
    `LCD4W_ASSERT(a_col_clear, clk, rst_n, (cmd.col_op == COL_CLEAR) |=> col_reg == '0)

endmodule

/* sim/tb.sv */
module tb;
    import lcd4w_pkg::*;

    localparam int LINE_LEN       = LINE_CHARS_DEFAULT;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int QUIET_CYCLES   = 8;

    typedef struct packed {
        logic                rs;
        logic                en;
        logic [NIBBLE_W-1:0] nib;
        logic [HOLD_W-1:0]   hold;
        logic                last;
    } pin_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcd4w_req_if req_if();
    lcd4w_res_if res_if();

    char_lcd_4bit_write_sequencer_core #(
        .LINE_CHARS(LINE_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .result   (res_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    pin_word_t         pin_q[$];
    logic [PULSE_W-1:0] pulse_len;
    logic [WAIT_W-1:0]  data_settle;
    logic [WAIT_W-1:0]  cmd_settle;
    logic [WAIT_W-1:0]  start_settle;
    logic [COL_W-1:0]   column;

    int unsigned error_count;
    int unsigned word_count;
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned idle_cycles;
    logic        hold_active;
    event        hold_off_start;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t, word %0d: %s", $time, word_count, msg);
        error_count++;
    endtask

    function automatic void queue_pin_word(input logic rs, input logic en,
                                           input logic [NIBBLE_W-1:0] nib,
                                           input logic [HOLD_W-1:0] hold);
        pin_word_t w;
        w.rs   = rs;
        w.en   = en;
        w.nib  = nib;
        w.hold = hold;
        w.last = 1'b0;
        pin_q.push_back(w);
    endfunction

    function automatic void queue_lcd_byte(input logic rs, input logic [BYTE_W-1:0] b,
                                           input logic [HOLD_W-1:0] settle);
        logic [HOLD_W-1:0] pulse_hold;
        pulse_hold = HOLD_W'(pulse_len);
        queue_pin_word(rs, 1'b1, b[7:4], pulse_hold);
        queue_pin_word(rs, 1'b0, b[7:4], pulse_hold);
        queue_pin_word(rs, 1'b1, b[3:0], pulse_hold);
        queue_pin_word(rs, 1'b0, b[3:0], settle);
    endfunction

    function automatic void predict_pin_words(input logic [OPCODE_W-1:0] op,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [LINE_SEL_W-1:0] ls);
        logic [BYTE_W-1:0] power_up_cmds [6];
        logic [HOLD_W-1:0] cmd_hold;
        logic [HOLD_W-1:0] data_hold;
        int unsigned       queued_before;
        power_up_cmds = '{8'h33, 8'h33, 8'h32, 8'h28, 8'h0C, 8'h01};
        cmd_hold      = HOLD_W'(cmd_settle);
        data_hold     = HOLD_W'(data_settle);
        queued_before = pin_q.size();
        case (op)
            OP_COMMAND: queue_lcd_byte(1'b0, b, cmd_hold);
            OP_DATA:
            begin
                queue_lcd_byte(1'b1, b, data_hold);
                if (column < LINE_LEN)
                    column++;
            end
            OP_INIT:
            begin
                queue_pin_word(1'b0, 1'b0, '0, HOLD_W'(start_settle));
                for (int i = 0; i < 5; i++)
                    queue_lcd_byte(1'b0, power_up_cmds[i], cmd_hold);
                queue_lcd_byte(1'b0, power_up_cmds[5], cmd_hold + HOLD_W'(start_settle));
                column = '0;
            end
            OP_LINE:
            begin
                queue_lcd_byte(1'b0, (ls == LINE_TWO_SEL) ? LINE_TWO_ADDR : LINE_ONE_ADDR,
                               cmd_hold + cmd_hold);
                column = '0;
            end
            OP_PAD:
            begin
                while (column < LINE_LEN)
                begin
                    queue_lcd_byte(1'b1, SPACE_CHAR, data_hold);
                    column++;
                end
            end
            default: ;
        endcase
        if (pin_q.size() > queued_before)
            pin_q[pin_q.size()-1].last = 1'b1;
    endfunction

    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b,
                                input logic [LINE_SEL_W-1:0] ls);
        int unsigned gap;
        gap = 0;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.byte_value  <= b;
        req_if.line_select <= ls;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predict_pin_words(op, b, ls);
    endtask

    task automatic send_random(input logic [OPCODE_W-1:0] op);
        send_request(op, BYTE_W'($urandom), LINE_SEL_W'($urandom));
    endtask

    // drop valid and hold until every pending word has come back
    task automatic pause_until_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pin_q.size() != 0);
    endtask

    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        while (pin_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_PULSE:   pulse_len    = val[PULSE_W-1:0];
            CFG_DATA:    data_settle  = val;
            CFG_COMMAND: cmd_settle   = val;
            CFG_STARTUP: start_settle = val;
            default: ;
        endcase
    endtask

    task automatic load_timing(input logic [PULSE_W-1:0] p, input logic [WAIT_W-1:0] d,
                               input logic [WAIT_W-1:0] c, input logic [WAIT_W-1:0] s);
        wait_quiet();
        write_reg(CFG_PULSE, CFG_DATA_W'(p));
        write_reg(CFG_DATA, d);
        write_reg(CFG_COMMAND, c);
        write_reg(CFG_STARTUP, s);
        cfg_we <= 1'b0;
    endtask

    task automatic load_random_timing();
        load_timing(PULSE_W'($urandom_range(1, 255)), WAIT_W'($urandom),
                    WAIT_W'($urandom), WAIT_W'($urandom));
    endtask

    task automatic set_idling(input int unsigned g, input int unsigned s);
        gap_pct   = g;
        stall_pct = s;
    endtask

    task automatic run_random_traffic(input int unsigned target);
        int unsigned sent;
        int unsigned n_chars;
        int unsigned pick;
        logic [OPCODE_W-1:0] op;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                send_random(OP_LINE);
                n_chars = $urandom_range(20);
                repeat (n_chars) send_random(OP_DATA);
                if ($urandom_range(1) == 1)
                begin
                    send_random(OP_PAD);
                    sent++;
                end
                sent += n_chars + 1;
            end
            else if (pick < 68)
            begin
                send_random(OP_INIT);
                sent++;
            end
            else if (pick < 84)
            begin
                send_random(OP_COMMAND);
                sent++;
            end
            else
            begin
                op = OPCODE_W'($urandom_range(7));
                send_random(op);
                if (op <= OP_PAD)
                    sent++;
            end
            if ($urandom_range(19) == 0)
                pause_until_drained();
        end
    endtask

    task automatic test_reset_defaults();
        set_idling(0, 0);
        send_request(OP_INIT, 8'h00, 2'd0);
        send_request(OP_DATA, 8'h41, 2'd0);
        send_request(OP_DATA, 8'h00, 2'd3);
        send_request(OP_DATA, 8'hFF, 2'd0);
        send_request(OP_PAD, 8'h00, 2'd0);
        send_request(OP_PAD, 8'hFF, 2'd3);
        send_request(OP_LINE, 8'h00, LINE_TWO_SEL);
        send_request(OP_COMMAND, 8'h00, 2'd0);
        send_request(OP_COMMAND, 8'hFF, 2'd3);
        send_request(OP_LINE, 8'hFF, 2'd0);
        send_request(OP_LINE, 8'h00, 2'd1);
        send_request(OP_LINE, 8'h00, 2'd3);
        send_request(3'd5, 8'hFF, 2'd3);
        send_request(3'd6, 8'h00, 2'd0);
        send_request(3'd7, 8'hA5, 2'd2);
        send_request(OP_DATA, 8'hA5, 2'd1);
        send_request(OP_PAD, 8'h5A, 2'd2);
    endtask

    task automatic test_timing_extremes();
        load_timing(8'd1, 16'd0, 16'd0, 16'd0);
        send_request(OP_INIT, 8'h00, 2'd0);
        send_request(OP_DATA, 8'h5A, 2'd0);
        send_request(OP_LINE, 8'h00, LINE_TWO_SEL);
        send_request(OP_PAD, 8'h00, 2'd0);
        send_request(OP_COMMAND, 8'h0F, 2'd0);
        load_timing(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_INIT, 8'h00, 2'd0);
        send_request(OP_LINE, 8'h00, 2'd1);
        send_request(OP_DATA, 8'hC3, 2'd0);
        send_request(OP_PAD, 8'h00, 2'd0);
        send_request(OP_COMMAND, 8'hF0, 2'd0);
    endtask

    task automatic test_random_phases();
        load_random_timing();
        set_idling(0, 0);
        run_random_traffic(80);
        load_random_timing();
        set_idling(77, 0);
        run_random_traffic(80);
        load_random_timing();
        set_idling(0, 77);
        run_random_traffic(80);
        load_timing(PULSE_RESET, DATA_RESET, COMMAND_RESET, STARTUP_RESET);
        set_idling(26, 26);
        run_random_traffic(80);
    endtask

    task automatic test_output_hold_off();
        wait_quiet();
        set_idling(0, 0);
        -> hold_off_start;
        send_request(OP_LINE, 8'h00, 2'd0);
        for (int i = 0; i < 8; i++)
            send_random(OP_DATA);
        send_request(OP_PAD, 8'h00, 2'd0);
        send_request(OP_INIT, 8'h00, 2'd0);
        send_random(OP_COMMAND);
        wait_quiet();
    endtask

    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_off_start);
            hold_active <= 1'b1;
            repeat (HOLD_OFF_LEN) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (pin_q.size() == 0)
                    report_mismatch("word arrived with nothing pending");
                else
                begin
                    pin_word_t want;
                    want = pin_q.pop_front();
                    if (res_if.reg_select !== want.rs)
                        report_mismatch($sformatf("reg_select got %0d expected %0d",
                                                  res_if.reg_select, want.rs));
                    if (res_if.enable !== want.en)
                        report_mismatch($sformatf("enable got %0d expected %0d",
                                                  res_if.enable, want.en));
                    if (res_if.nibble !== want.nib)
                        report_mismatch($sformatf("nibble got %0h expected %0h",
                                                  res_if.nibble, want.nib));
                    if (res_if.hold_us !== want.hold)
                        report_mismatch($sformatf("hold_us got %0d expected %0d",
                                                  res_if.hold_us, want.hold));
                    if (res_if.last !== want.last)
                        report_mismatch($sformatf("last got %0d expected %0d",
                                                  res_if.last, want.last));
                end
                word_count++;
            end
            if (hold_active)
                res_if.ready <= 1'b0;
            else
                res_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        error_count        = 0;
        word_count         = 0;
        gap_pct            = 0;
        stall_pct          = 0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_PULSE;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.opcode      = '0;
        req_if.byte_value  = '0;
        req_if.line_select = '0;
        pulse_len          = PULSE_RESET;
        data_settle        = DATA_RESET;
        cmd_settle         = COMMAND_RESET;
        start_settle       = STARTUP_RESET;
        column             = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_timing_extremes();
        test_random_phases();
        test_output_hold_off();

        wait_quiet();
        if (error_count == 0 && pin_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
